/* rtl/http_chunked_body_decoder_macros.svh */
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HCBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chunked decoder: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define HCBD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chunked decoder: next-cycle check failed");

`endif

/* rtl/hcbd_pkg.sv */
// Package: phase type, character codes, marker text, queue sizes, result bundle and hex decoder.
package hcbd_pkg;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_PASS   = 3'd1,
		PH_SIZE   = 3'd2,
		PH_DATA   = 3'd3,
		PH_TRAIL  = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	localparam logic [7:0] CHR_CR = 8'h0d;
	localparam logic [7:0] CHR_LF = 8'h0a;
	localparam logic [7:0] CHR_T  = 8'h54;

	localparam logic [4:0] MARKER_LEN = 5'd26;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int MAX_RES    = 4;

	typedef struct packed {
		logic [2:0]      num;
		logic [3:0][7:0] bytes;
		logic            done;
	} hcbd_res_t;

	function automatic logic [7:0] marker_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = "T";
			5'd1:  c = "r";
			5'd2:  c = "a";
			5'd3:  c = "n";
			5'd4:  c = "s";
			5'd5:  c = "f";
			5'd6:  c = "e";
			5'd7:  c = "r";
			5'd8:  c = "-";
			5'd9:  c = "E";
			5'd10: c = "n";
			5'd11: c = "c";
			5'd12: c = "o";
			5'd13: c = "d";
			5'd14: c = "i";
			5'd15: c = "n";
			5'd16: c = "g";
			5'd17: c = ":";
			5'd18: c = " ";
			5'd19: c = "c";
			5'd20: c = "h";
			5'd21: c = "u";
			5'd22: c = "n";
			5'd23: c = "k";
			5'd24: c = "e";
			5'd25: c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(b - 8'h37)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

/* rtl/hcbd_parse.sv */
// Parser: header scan, chunk size decode and body rewrite for one byte per step.
module hcbd_parse import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       request_start,
	output hcbd_res_t  res
);

	phase_t                 phase_q, phase_c, phase_n;
	logic [1:0]             blank_q, blank_c, blank_n;
	logic [4:0]             midx_q, midx_c, midx_n;
	logic                   seen_q, seen_c, seen_n;
	logic [SIZE_BITS-1:0]   cnt_q, cnt_c, cnt_n;
	logic                   ended_q, ended_c, ended_n;
	logic [1:0]             wait_q, wait_c, wait_n;
	logic [2:0]             blank_sum;
	logic [4:0]             hex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			blank_q <= '0;
			midx_q  <= '0;
			seen_q  <= 1'b0;
			cnt_q   <= '0;
			ended_q <= 1'b0;
			wait_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			blank_q <= blank_n;
			midx_q  <= midx_n;
			seen_q  <= seen_n;
			cnt_q   <= cnt_n;
			ended_q <= ended_n;
			wait_q  <= wait_n;
		end
	end

	always_comb begin
		if (request_start) begin
			phase_c = PH_HEADER;
			blank_c = '0;
			midx_c  = '0;
			seen_c  = 1'b0;
			cnt_c   = '0;
			ended_c = 1'b0;
			wait_c  = '0;
		end else begin
			phase_c = phase_q;
			blank_c = blank_q;
			midx_c  = midx_q;
			seen_c  = seen_q;
			cnt_c   = cnt_q;
			ended_c = ended_q;
			wait_c  = wait_q;
		end

		phase_n   = phase_c;
		blank_n   = blank_c;
		midx_n    = midx_c;
		seen_n    = seen_c;
		cnt_n     = cnt_c;
		ended_n   = ended_c;
		wait_n    = wait_c;
		blank_sum = '0;
		hex       = hex_decode(data_byte);
		res       = '0;

		case (phase_c)
			PH_HEADER: begin
				if (!seen_c) begin
					if (midx_c < MARKER_LEN && data_byte == marker_char(midx_c)) begin
						midx_n = midx_c + 5'd1;
					end else begin
						midx_n = (data_byte == CHR_T) ? 5'd1 : 5'd0;
					end
					if (midx_n == MARKER_LEN) begin
						seen_n = 1'b1;
						midx_n = '0;
					end
				end
				if (data_byte == (blank_c[0] ? CHR_LF : CHR_CR)) begin
					blank_sum = {1'b0, blank_c} + 3'd1;
				end else begin
					blank_sum = (data_byte == CHR_CR) ? 3'd1 : 3'd0;
				end
				if (blank_sum == 3'd4) begin
					blank_n = '0;
					phase_n = seen_n ? PH_SIZE : PH_PASS;
					cnt_n   = '0;
					ended_n = 1'b0;
				end else begin
					blank_n = blank_sum[1:0];
				end
				res.num      = 3'd1;
				res.bytes[0] = data_byte;
			end
			PH_PASS: begin
				res.num      = 3'd1;
				res.bytes[0] = data_byte;
			end
			PH_SIZE: begin
				if (!ended_c && hex[4]) begin
					if (|cnt_c[SIZE_BITS-1 -: 4]) begin
						cnt_n = '1;
					end else begin
						cnt_n = {cnt_c[SIZE_BITS-5:0], hex[3:0]};
					end
				end else if (!ended_c && cnt_c == '0) begin
					ended_n      = 1'b1;
					phase_n      = PH_DONE;
					res.num      = 3'd4;
					res.bytes[0] = CHR_CR;
					res.bytes[1] = CHR_LF;
					res.bytes[2] = CHR_CR;
					res.bytes[3] = CHR_LF;
					res.done     = 1'b1;
				end else begin
					ended_n = 1'b1;
					if (data_byte == CHR_LF) begin
						phase_n = PH_DATA;
						ended_n = 1'b0;
					end
				end
			end
			PH_DATA: begin
				cnt_n = cnt_c - 1'b1;
				if (cnt_n == '0) begin
					phase_n = PH_TRAIL;
					wait_n  = 2'd2;
				end
				res.num      = 3'd1;
				res.bytes[0] = data_byte;
			end
			PH_TRAIL: begin
				wait_n = (wait_c != 2'd0) ? wait_c - 2'd1 : 2'd0;
				if (wait_n == 2'd0) begin
					phase_n = PH_SIZE;
					cnt_n   = '0;
					ended_n = 1'b0;
				end
			end
			default: begin
				phase_n = phase_c;
			end
		endcase
	end

endmodule

/* rtl/http_chunked_body_decoder.sv */
// Top level: input register, byte parser and output queue of the chunked body decoder.
//
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  data_byte, request_start
// out      source     out_valid/out_stall out_byte, body_done
//
// One input beat per cycle while in_stall is low; each beat yields zero, one or four output beats.
// A beat waits in the input register until the parser takes it and writes its
// results into an 8-entry output queue; the queue must have four free slots.
// Hold the input while more than four beats wait, from out_stall or from the
// four bytes of the zero-size chunk line.
// Reset clears the parse to the header phase and empties the queue.
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       request_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       body_done
);

	`include "http_chunked_body_decoder_macros.svh"

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 start_s1;
	logic                 proc;
	logic                 pop;
	logic                 in_acc;
	hcbd_res_t            res;
	logic [8:0]           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q, rd_q;
	logic [FIFO_AW:0]     fill_q;
	logic [2:0]           push_num;

	assign proc     = valid_s1 && (fill_q <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RES));
	assign in_stall = valid_s1 && !proc;
	assign in_acc   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;
	assign push_num = proc ? res.num : 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= data_byte;
			start_s1 <= request_start;
		end
	end

	hcbd_parse #(
		.SIZE_BITS (SIZE_BITS)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (proc),
		.data_byte     (data_s1),
		.request_start (start_s1),
		.res           (res)
	);

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (proc && 3'(k) < res.num) begin
				mem_q[wr_q + FIFO_AW'(k)] <= {res.done && (k == MAX_RES - 1), res.bytes[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + FIFO_AW'(push_num);
			rd_q   <= rd_q + FIFO_AW'(pop);
			fill_q <= fill_q + (FIFO_AW + 1)'(push_num) - (FIFO_AW + 1)'(pop);
		end
	end

	assign out_valid = (fill_q != '0);
	assign out_byte  = mem_q[rd_q][7:0];
	assign body_done = mem_q[rd_q][8];

	`HCBD_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
	`HCBD_ASSERT_IMP(a_done_is_lf, out_valid && body_done, out_byte == CHR_LF)
	`HCBD_ASSERT_NXT(a_drain_last, pop && fill_q == 1 && !proc, !out_valid)

endmodule
